// File: src/crcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package crcm_pkg;

  localparam int unsigned MAX_CELLS_DEF = 1024;
  localparam int unsigned NUM_CAT_DEF   = 16;
  localparam int unsigned DIV_W         = 32;

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_LAYOUT = 2'd1,
    CMD_MARK   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [7:0] {
    REG_TOTAL_CLUSTERS = 8'd0,
    REG_MAP_CELLS      = 8'd1,
    REG_SYSTEM_CAT     = 8'd2,
    REG_UNCHECKED_CAT  = 8'd3
  } reg_idx_t;

  // datapath operations, one per cycle
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR_STEP,
    DP_INIT_STEP,
    DP_DIV_LT,
    DP_DIV_LC,
    DP_DIV_MK,
    DP_LAY_A,
    DP_LAY_B,
    DP_LAY_FILL,
    DP_MK_A,
    DP_MK_N,
    DP_RD_NEW,
    DP_WR_NEW,
    DP_RD_OLD,
    DP_WR_OLD,
    DP_MK_NEXT,
    DP_MUL_F,
    DP_MUL_C,
    DP_MK_END,
    DP_OW_STEP,
    DP_Q_RD,
    DP_Q_CMP,
    DP_RES
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic mode;
    logic each_zero;
    logic q_err;
    logic div_done;
    logic div_q_zero;
    logic sweep_last;
    logic cell_last;
    logic mk_go;
    logic ow_go;
    logic cat_last;
  } st_t;

endpackage
`default_nettype wire

// File: src/crcm_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface crcm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] start_cluster;
  logic [31:0] run_length;
  logic [3:0]  new_category;
  logic [3:0]  old_category;
  logic [9:0]  cell_index;
  modport source (output valid, cmd, start_cluster, run_length, new_category,
                  old_category, cell_index, input ready);
  modport sink (input valid, cmd, start_cluster, run_length, new_category,
                old_category, cell_index, output ready);
endinterface

interface crcm_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] dominant_category;
  logic       error;
  modport source (output valid, dominant_category, error, input ready);
  modport sink (input valid, dominant_category, error, output ready);
endinterface

interface crcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/cluster_run_category_map.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake     payload
// in_ch     in   valid/ready   cmd, start_cluster, run_length, new/old_category, cell_index
// out_ch    out  valid/ready   dominant_category, error
// cfg_ch    in   valid/ready   index, data (ready always high)
//
// One item at a time; the next item is taken while a result waits in the output register.
// Query: reads and compares each category in turn. Layout: one serial divide, then each cell
// is filled (clusters mode), or two serial divides (cells-per-cluster mode).
// Mark: one serial divide, then a read-modify-write of two counts per cell touched, or
// every category written per overwritten cell. Init: MAX_CELLS*2^clog2(NUM_CATEGORIES) words.
// After reset the count store is cleared, one word a cycle (16384 words at defaults);
// in_ch.ready stays low meanwhile. Results stall freely on out_ch.ready.
module cluster_run_category_map #(
  parameter int unsigned MAX_CELLS      = crcm_pkg::MAX_CELLS_DEF,
  parameter int unsigned NUM_CATEGORIES = crcm_pkg::NUM_CAT_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  crcm_in_if.sink     in_ch,
  crcm_out_if.source  out_ch,
  crcm_cfg_if.sink    cfg_ch
);
  crcm_pkg::ctl_t ctl;
  crcm_pkg::st_t  st;

  assign cfg_ch.ready = 1'b1;

  crcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .ctl       (ctl)
  );

  crcm_dp #(
    .MAX_CELLS      (MAX_CELLS),
    .NUM_CATEGORIES (NUM_CATEGORIES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctl                   (ctl),
    .st                    (st),
    .cfg_we                (cfg_ch.valid),
    .cfg_index             (cfg_ch.index),
    .cfg_data              (cfg_ch.data),
    .in_cmd                (in_ch.cmd),
    .in_start_cluster      (in_ch.start_cluster),
    .in_run_length         (in_ch.run_length),
    .in_new_category       (in_ch.new_category),
    .in_old_category       (in_ch.old_category),
    .in_cell_index         (in_ch.cell_index),
    .res_dominant_category (out_ch.dominant_category),
    .res_error             (out_ch.error)
  );

endmodule
`default_nettype wire

// File: src/crcm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// radix-2 restoring divider, one quotient bit per cycle
module crcm_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [crcm_pkg::DIV_W-1:0]    a,
  input  wire logic [crcm_pkg::DIV_W-1:0]    b,
  output logic      [crcm_pkg::DIV_W-1:0]    q,
  output logic      [crcm_pkg::DIV_W-1:0]    r,
  output logic                               done
);
  localparam int unsigned W  = crcm_pkg::DIV_W;
  localparam int unsigned CNW = $clog2(W);

  logic           busy_r;
  logic           done_r;
  logic [CNW-1:0] cnt_r;
  logic [W-1:0]   quo_r, rem_r, b_r;
  logic [W:0]     r2;
  logic           ge;

  always_comb begin
    r2 = {rem_r, quo_r[W-1]};
    ge = r2 >= {1'b0, b_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= a;
      rem_r <= '0;
      b_r   <= b;
    end else if (busy_r) begin
      quo_r <= {quo_r[W-2:0], ge};
      rem_r <= ge ? W'(r2 - {1'b0, b_r}) : W'(r2);
    end
  end

  assign q    = quo_r;
  assign r    = rem_r;
  assign done = done_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("divider done out of turn");

endmodule
`default_nettype wire

// File: src/crcm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module crcm_dp #(
  parameter int unsigned MAX_CELLS      = crcm_pkg::MAX_CELLS_DEF,
  parameter int unsigned NUM_CATEGORIES = crcm_pkg::NUM_CAT_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire crcm_pkg::ctl_t ctl,
  output crcm_pkg::st_t     st,
  // configuration writes
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  // item fields
  input  wire logic [1:0]   in_cmd,
  input  wire logic [31:0]  in_start_cluster,
  input  wire logic [31:0]  in_run_length,
  input  wire logic [3:0]   in_new_category,
  input  wire logic [3:0]   in_old_category,
  input  wire logic [9:0]   in_cell_index,
  // result
  output logic [3:0]        res_dominant_category,
  output logic              res_error
);
  localparam int unsigned ECW = $clog2(MAX_CELLS + 1);
  localparam int unsigned CLW = $clog2(MAX_CELLS);
  localparam int unsigned CW  = $clog2(NUM_CATEGORIES);
  localparam int unsigned AW  = CLW + CW;
  localparam int unsigned WP  = 32 + ECW;

  // configuration
  logic [31:0] total_r;
  logic [10:0] map_r;
  logic [3:0]  sys_r, unch_r;

  // layout state
  logic           mode_r;
  logic [31:0]    each_r, final_r;
  logic [ECW-1:0] ceach_r, cfin_r;

  // item working registers
  crcm_pkg::cmd_t cmd_r;
  logic [31:0]    start_r, len_r, off_r, n_r, cell_r, top_r;
  logic [3:0]     newc_r, oldc_r;
  logic           q_err_r;
  logic [CW-1:0]  cat_r, best_r;
  logic [AW-1:0]  wa_r;
  logic [WP-1:0]  first_r, prod_r;
  logic [ECW-1:0] end_r;
  logic [3:0]     res_dom_r;
  logic           res_err_r;

  // store
  logic [31:0] mem_r [0:(2**AW)-1];
  logic [31:0] rdata_r;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;

  // divider
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q, div_r;

  logic [ECW-1:0] eff, effm1;
  logic [31:0]    total_eff;
  logic           cell_below, cell_at_last, cat_last;
  logic           sys_ok, newc_ok, oldc_ok;
  logic [31:0]    avail, nval;
  logic [32:0]    sat_sum;
  logic [WP:0]    endv;
  logic [WP-1:0]  extra;
  logic [CW-1:0]  init_cat;
  logic [CLW-1:0] init_cell;

  always_comb begin
    if (map_r == 11'd0) begin
      eff = ECW'(1);
    end else if (32'(map_r) > 32'(MAX_CELLS)) begin
      eff = ECW'(MAX_CELLS);
    end else begin
      eff = ECW'(map_r);
    end
    effm1        = eff - 1'b1;
    total_eff    = (total_r == 32'd0) ? 32'd1 : total_r;
    cell_below   = cell_r < 32'(effm1);
    cell_at_last = cell_r == 32'(effm1);
    cat_last     = cat_r == CW'(NUM_CATEGORIES - 1);
    sys_ok       = 32'(sys_r) < NUM_CATEGORIES;
    newc_ok      = 32'(newc_r) < NUM_CATEGORIES;
    oldc_ok      = 32'(oldc_r) < NUM_CATEGORIES;
    avail        = cell_at_last ? (final_r - off_r) : (each_r - off_r);
    nval         = (len_r < avail) ? len_r : avail;
    sat_sum      = 33'(rdata_r) + 33'(n_r);
    if ((33'(start_r) + 33'(len_r) == 33'(total_eff)) && (cfin_r >= ceach_r)) begin
      extra = WP'(cfin_r - ceach_r);
    end else begin
      extra = '0;
    end
    endv      = (WP + 1)'(first_r) + (WP + 1)'(prod_r) + (WP + 1)'(extra);
    init_cat  = wa_r[CW-1:0];
    init_cell = wa_r[AW-1:CW];
  end

  // store port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = wa_r;
    raddr = {cell_r[CLW-1:0], cat_r};
    wdata = 32'd0;
    unique case (ctl.op)
      crcm_pkg::DP_CLR_STEP: begin
        we = 1'b1;
      end
      crcm_pkg::DP_INIT_STEP: begin
        we    = 1'b1;
        wdata = (32'(init_cell) < 32'(eff) && sys_ok && init_cat == CW'(sys_r)) ? 32'd1
                                                                                : 32'd0;
      end
      crcm_pkg::DP_LAY_FILL: begin
        we    = sys_ok;
        waddr = {cell_r[CLW-1:0], CW'(sys_r)};
        wdata = cell_at_last ? final_r : each_r;
      end
      crcm_pkg::DP_RD_NEW: begin
        re    = 1'b1;
        raddr = {cell_r[CLW-1:0], CW'(newc_r)};
      end
      crcm_pkg::DP_WR_NEW: begin
        we    = newc_ok;
        waddr = {cell_r[CLW-1:0], CW'(newc_r)};
        wdata = sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
      end
      crcm_pkg::DP_RD_OLD: begin
        re    = 1'b1;
        raddr = {cell_r[CLW-1:0], CW'(oldc_r)};
      end
      crcm_pkg::DP_WR_OLD: begin
        we    = oldc_ok;
        waddr = {cell_r[CLW-1:0], CW'(oldc_r)};
        wdata = (rdata_r >= n_r) ? (rdata_r - n_r) : 32'd0;
      end
      crcm_pkg::DP_OW_STEP: begin
        we    = 1'b1;
        waddr = {cell_r[CLW-1:0], cat_r};
        wdata = (32'(cat_r) == 32'(newc_r)) ? 32'd1 : 32'd0;
      end
      crcm_pkg::DP_Q_RD: begin
        re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_a     = start_r;
    div_b     = each_r;
    unique case (ctl.op)
      crcm_pkg::DP_DIV_LT: begin
        div_start = 1'b1;
        div_a     = total_eff;
        div_b     = 32'(eff);
      end
      crcm_pkg::DP_DIV_LC: begin
        div_start = 1'b1;
        div_a     = 32'(eff);
        div_b     = total_eff;
      end
      crcm_pkg::DP_DIV_MK: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  crcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .q     (div_q),
    .r     (div_r),
    .done  (div_done)
  );

  // configuration and layout state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 32'd1;
      map_r   <= 11'd1024;
      sys_r   <= 4'd0;
      unch_r  <= 4'd0;
      mode_r  <= 1'b0;
      each_r  <= 32'd0;
      final_r <= 32'd0;
      ceach_r <= '0;
      cfin_r  <= '0;
      wa_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          crcm_pkg::REG_TOTAL_CLUSTERS: total_r <= cfg_data;
          crcm_pkg::REG_MAP_CELLS:      map_r   <= cfg_data[10:0];
          crcm_pkg::REG_SYSTEM_CAT:     sys_r   <= cfg_data[3:0];
          crcm_pkg::REG_UNCHECKED_CAT:  unch_r  <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
      unique case (ctl.op)
        crcm_pkg::DP_LAY_A: begin
          each_r <= div_q;
          if (div_q != 32'd0) begin
            mode_r  <= 1'b0;
            final_r <= div_q + div_r;
          end else begin
            mode_r <= 1'b1;
          end
        end
        crcm_pkg::DP_LAY_B: begin
          ceach_r <= ECW'(div_q);
          cfin_r  <= ECW'(div_q + div_r);
        end
        crcm_pkg::DP_LOAD: wa_r <= '0;
        crcm_pkg::DP_CLR_STEP, crcm_pkg::DP_INIT_STEP: wa_r <= wa_r + 1'b1;
        default: begin
        end
      endcase
    end
  end

  // item working registers
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      crcm_pkg::DP_LOAD: begin
        cmd_r   <= crcm_pkg::cmd_t'(in_cmd);
        start_r <= in_start_cluster;
        len_r   <= in_run_length;
        newc_r  <= in_new_category;
        oldc_r  <= in_old_category;
        cell_r  <= 32'(in_cell_index);
        cat_r   <= '0;
        q_err_r <= 32'(in_cell_index) >= 32'(eff);
      end
      crcm_pkg::DP_LAY_A: cell_r <= 32'd0;
      crcm_pkg::DP_LAY_FILL: cell_r <= cell_r + 32'd1;
      crcm_pkg::DP_MK_A: begin
        cell_r <= div_q;
        off_r  <= div_r;
      end
      crcm_pkg::DP_MK_N: n_r <= nval;
      crcm_pkg::DP_MK_NEXT: begin
        len_r  <= len_r - n_r;
        cell_r <= cell_r + 32'd1;
        off_r  <= 32'd0;
      end
      crcm_pkg::DP_MUL_F: prod_r <= WP'(start_r) * WP'(ceach_r);
      crcm_pkg::DP_MUL_C: begin
        first_r <= prod_r;
        prod_r  <= WP'(len_r) * WP'(ceach_r);
      end
      crcm_pkg::DP_MK_END: begin
        end_r  <= (endv > (WP + 1)'(eff)) ? eff : ECW'(endv);
        cell_r <= (first_r >= WP'(eff)) ? 32'(eff) : 32'(first_r);
      end
      crcm_pkg::DP_OW_STEP: begin
        if (cat_last) begin
          cat_r  <= '0;
          cell_r <= cell_r + 32'd1;
        end else begin
          cat_r <= cat_r + 1'b1;
        end
      end
      crcm_pkg::DP_Q_CMP: begin
        if (cat_r == '0) begin
          top_r  <= rdata_r;
          best_r <= '0;
        end else if (rdata_r > top_r ||
                     (rdata_r == top_r && 32'(cat_r) != 32'(unch_r))) begin
          top_r  <= rdata_r;
          best_r <= cat_r;
        end
        cat_r <= cat_last ? '0 : cat_r + 1'b1;
      end
      crcm_pkg::DP_RES: begin
        res_err_r <= (cmd_r == crcm_pkg::CMD_QUERY) && q_err_r;
        res_dom_r <= ((cmd_r == crcm_pkg::CMD_QUERY) && !q_err_r) ? 4'(best_r) : 4'd0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st.cmd        = cmd_r;
    st.mode       = mode_r;
    st.each_zero  = each_r == 32'd0;
    st.q_err      = q_err_r;
    st.div_done   = div_done;
    st.div_q_zero = div_q == 32'd0;
    st.sweep_last = wa_r == '1;
    st.cell_last  = cell_at_last;
    st.mk_go      = (len_r != 32'd0) && (cell_below || (cell_at_last && off_r < final_r));
    st.ow_go      = cell_r < 32'(end_r);
    st.cat_last   = cat_last;
  end

  assign res_dominant_category = res_dom_r;
  assign res_error             = res_err_r;

endmodule
`default_nettype wire

// File: src/crcm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module crcm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire crcm_pkg::st_t  st,
  output crcm_pkg::ctl_t      ctl
);
  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP, S_INIT,
    S_LDIV1, S_LW1, S_LA, S_LDIV2, S_LW2, S_LB, S_LFILL,
    S_MDIV, S_MW, S_MA, S_MCHK, S_RDN, S_WRN, S_RDO, S_WRO, S_MNX,
    S_MM1, S_MM2, S_MM3, S_OW,
    S_QRD, S_QCMP, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   acc, res_ok;

  assign acc    = in_valid && (state_r == S_IDLE);
  assign res_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    ctl.op    = crcm_pkg::DP_NOP;
    unique case (state_r)
      S_CLR: begin
        ctl.op = crcm_pkg::DP_CLR_STEP;
        if (st.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          ctl.op    = crcm_pkg::DP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.cmd)
          crcm_pkg::CMD_INIT:   state_nxt = S_INIT;
          crcm_pkg::CMD_LAYOUT: state_nxt = S_LDIV1;
          crcm_pkg::CMD_MARK: begin
            priority if (st.mode)      state_nxt = S_MM1;
            else if (st.each_zero)     state_nxt = S_DONE;
            else                       state_nxt = S_MDIV;
          end
          crcm_pkg::CMD_QUERY:  state_nxt = st.q_err ? S_DONE : S_QRD;
          default:              state_nxt = S_DONE;
        endcase
      end
      S_INIT: begin
        ctl.op = crcm_pkg::DP_INIT_STEP;
        if (st.sweep_last) state_nxt = S_DONE;
      end
      S_LDIV1: begin
        ctl.op    = crcm_pkg::DP_DIV_LT;
        state_nxt = S_LW1;
      end
      S_LW1: if (st.div_done) state_nxt = S_LA;
      S_LA: begin
        ctl.op    = crcm_pkg::DP_LAY_A;
        state_nxt = st.div_q_zero ? S_LDIV2 : S_LFILL;
      end
      S_LDIV2: begin
        ctl.op    = crcm_pkg::DP_DIV_LC;
        state_nxt = S_LW2;
      end
      S_LW2: if (st.div_done) state_nxt = S_LB;
      S_LB: begin
        ctl.op    = crcm_pkg::DP_LAY_B;
        state_nxt = S_DONE;
      end
      S_LFILL: begin
        ctl.op = crcm_pkg::DP_LAY_FILL;
        if (st.cell_last) state_nxt = S_DONE;
      end
      S_MDIV: begin
        ctl.op    = crcm_pkg::DP_DIV_MK;
        state_nxt = S_MW;
      end
      S_MW: if (st.div_done) state_nxt = S_MA;
      S_MA: begin
        ctl.op    = crcm_pkg::DP_MK_A;
        state_nxt = S_MCHK;
      end
      S_MCHK: begin
        if (st.mk_go) begin
          ctl.op    = crcm_pkg::DP_MK_N;
          state_nxt = S_RDN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDN: begin
        ctl.op    = crcm_pkg::DP_RD_NEW;
        state_nxt = S_WRN;
      end
      S_WRN: begin
        ctl.op    = crcm_pkg::DP_WR_NEW;
        state_nxt = S_RDO;
      end
      S_RDO: begin
        ctl.op    = crcm_pkg::DP_RD_OLD;
        state_nxt = S_WRO;
      end
      S_WRO: begin
        ctl.op    = crcm_pkg::DP_WR_OLD;
        state_nxt = S_MNX;
      end
      S_MNX: begin
        ctl.op    = crcm_pkg::DP_MK_NEXT;
        state_nxt = S_MCHK;
      end
      S_MM1: begin
        ctl.op    = crcm_pkg::DP_MUL_F;
        state_nxt = S_MM2;
      end
      S_MM2: begin
        ctl.op    = crcm_pkg::DP_MUL_C;
        state_nxt = S_MM3;
      end
      S_MM3: begin
        ctl.op    = crcm_pkg::DP_MK_END;
        state_nxt = S_OW;
      end
      S_OW: begin
        if (st.ow_go) ctl.op = crcm_pkg::DP_OW_STEP;
        else          state_nxt = S_DONE;
      end
      S_QRD: begin
        ctl.op    = crcm_pkg::DP_Q_RD;
        state_nxt = S_QCMP;
      end
      S_QCMP: begin
        ctl.op    = crcm_pkg::DP_Q_CMP;
        state_nxt = st.cat_last ? S_DONE : S_QRD;
      end
      S_DONE: begin
        if (res_ok) begin
          ctl.op    = crcm_pkg::DP_RES;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.op == crcm_pkg::DP_RES) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> state_r == S_CLR) else $error("no clearing pass after reset");
  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == crcm_pkg::DP_RES |-> !out_valid_r || out_ready)
    else $error("result overwritten before taken");
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r == S_DISP) else $error("accepted item not dispatched");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == crcm_pkg::DP_RES |=> out_valid_r && state_r == S_IDLE)
    else $error("result not presented");

endmodule
`default_nettype wire
